### rtl/npic_pkg.sv
// npic_pkg: widths, command codes and the priority encoder of the interrupt controller
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package npic_pkg;

   localparam int LEVELS = 5;
   localparam int LVL_W = 3;
   localparam int TICK_W = 8;
   localparam int MASK_W = LEVELS;
   localparam int IDX_W = $clog2(LEVELS);

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [TICK_W-1:0] SERVICE_RESET = TICK_W'(5);

   typedef logic [LVL_W-1:0] level_type;
   typedef logic [TICK_W-1:0] ticks_type;
   typedef logic [MASK_W-1:0] mask_type;

   typedef struct packed {
      level_type active_level;
      ticks_type remaining;
      level_type finished_level;
      mask_type pending_mask;
      logic switched;
   } result_type;

   // highest set bit as a level number, 0 when empty
   function automatic level_type highest_level(input mask_type mask);
      level_type lv;
      lv = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (mask[i]) begin
            lv = LVL_W'(i + 1);
         end
      end
      return lv;
   endfunction

endpackage

`default_nettype wire

### rtl/npic_channels.sv
// npic channels: request, response and register write handshakes of the controller
// depends on npic_pkg
`default_nettype none

interface npic_req_chan;
   logic valid;
   logic ready;
   logic command;
   logic [npic_pkg::LVL_W-1:0] level;

   modport source (output valid, command, level, input ready);
   modport sink (input valid, command, level, output ready);
endinterface

interface npic_rsp_chan;
   logic valid;
   logic ready;
   logic [npic_pkg::LVL_W-1:0] active_level;
   logic [npic_pkg::TICK_W-1:0] remaining;
   logic [npic_pkg::LVL_W-1:0] finished_level;
   logic [npic_pkg::MASK_W-1:0] pending_mask;
   logic switched;

   modport source (output valid, active_level, remaining, finished_level, pending_mask,
                   switched, input ready);
   modport sink (input valid, active_level, remaining, finished_level, pending_mask,
                 switched, output ready);
endinterface

interface npic_csr_chan;
   logic valid;
   logic ready;
   logic [npic_pkg::TICK_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/nested_priority_interrupt_controller.sv
// nested_priority_interrupt_controller: five level nested interrupt controller
// depends on npic_pkg and the channel interfaces in npic_channels.sv
//
//   channel   direction  contents
//   req_if    in         command (request / tick), level
//   rsp_if    out        active_level, remaining, finished_level, pending_mask, switched
//   csr_if    in         service_ticks write data
//
// one request per cycle while the skid entry is empty; each response is registered.
// the path is one priority encode over the pending bits and one 8 bit decrement.
// a two entry output buffer (result register plus skid) lets a request in while a
// response waits; requests stop only when both entries are full.
// reset clears the pending bits and saved tick counts and sets service_ticks to 5.
`default_nettype none

module nested_priority_interrupt_controller (
   input wire logic clock,
   input wire logic reset,
   npic_req_chan.sink req_if,
   npic_rsp_chan.source rsp_if,
   npic_csr_chan.sink csr_if
);
   import npic_pkg::*;

   ticks_type service_ff;
   mask_type pending_ff, pending_in;
   level_type current_ff, current_in;
   ticks_type cur_ticks_ff, cur_ticks_in;
   ticks_type saved_ff [LEVELS];
   logic save_en;
   ticks_type save_val;

   result_type out_ff, skid_ff, result;
   logic out_valid_ff, skid_valid_ff;

   logic push, in_range, enter, done, is_active;
   mask_type req_bit, cur_bit;
   level_type hp, fin_lvl;
   logic [IDX_W-1:0] hp_idx, cur_idx;
   ticks_type saved_rd, fresh;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !skid_valid_ff;
   assign push = req_if.valid && req_if.ready;

   assign is_active = current_ff != '0;
   assign in_range = req_if.level != '0 && req_if.level <= LVL_W'(LEVELS);
   assign req_bit = in_range ? (MASK_W'(1) << (req_if.level - LVL_W'(1))) : '0;
   assign cur_bit = is_active ? (MASK_W'(1) << (current_ff - LVL_W'(1))) : '0;
   assign cur_idx = is_active ? IDX_W'(current_ff - LVL_W'(1)) : '0;
   assign done = cur_ticks_ff <= TICK_W'(1);

   always_comb begin
      pending_in = pending_ff;
      enter = 1'b0;
      fin_lvl = '0;
      if (req_if.command == CMD_REQUEST) begin
         pending_in = pending_ff | req_bit;
         enter = in_range && req_if.level > current_ff;
      end else if (is_active && done) begin
         pending_in = pending_ff & ~cur_bit;
         enter = 1'b1;
         fin_lvl = current_ff;
      end
   end

   assign hp = highest_level(pending_in);
   assign hp_idx = (hp != '0) ? IDX_W'(hp - LVL_W'(1)) : '0;
   assign saved_rd = saved_ff[hp_idx];
   assign fresh = (saved_rd != '0) ? saved_rd :
                  ((service_ff == '0) ? TICK_W'(1) : service_ff);

   always_comb begin
      current_in = current_ff;
      cur_ticks_in = cur_ticks_ff;
      save_en = 1'b0;
      save_val = '0;
      if (enter) begin
         current_in = hp;
         cur_ticks_in = (hp != '0) ? fresh : '0;
         save_en = is_active;
         // preempted level keeps its count, a finished one goes back to zero
         save_val = (req_if.command == CMD_REQUEST) ? cur_ticks_ff : '0;
      end else if (req_if.command == CMD_TICK && is_active) begin
         cur_ticks_in = cur_ticks_ff - TICK_W'(1);
      end
   end

   assign result.active_level = current_in;
   assign result.remaining = cur_ticks_in;
   assign result.finished_level = fin_lvl;
   assign result.pending_mask = pending_in;
   assign result.switched = enter && hp != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         service_ff <= SERVICE_RESET;
         pending_ff <= '0;
         current_ff <= '0;
         cur_ticks_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            saved_ff[i] <= '0;
         end
      end else begin
         if (csr_if.valid) begin
            service_ff <= csr_if.data;
         end
         if (push) begin
            pending_ff <= pending_in;
            current_ff <= current_in;
            cur_ticks_ff <= cur_ticks_in;
            if (save_en) begin
               saved_ff[cur_idx] <= save_val;
            end
         end
      end
   end

   // result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_if.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_if.ready) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.active_level = out_ff.active_level;
   assign rsp_if.remaining = out_ff.remaining;
   assign rsp_if.finished_level = out_ff.finished_level;
   assign rsp_if.pending_mask = out_ff.pending_mask;
   assign rsp_if.switched = out_ff.switched;

endmodule

`default_nettype wire

### dv/nested_priority_interrupt_controller_tb.sv
// testbench for nested_priority_interrupt_controller: directed table then random requests,
// each response checked against a fixed table want or the in-bench nested priority model
// depends on npic_pkg, the npic channel interfaces and the controller rtl
`timescale 1ns / 100ps

module nested_priority_interrupt_controller_tb;
   import npic_pkg::*;

   typedef struct packed {
      logic cmd;
      level_type lvl;
      logic fixed_want;
      result_type want;
   } stim_row_type;

   localparam result_type IDLE_RSP = '0;
   localparam int NUM_ROWS = 24;
   localparam int NUM_PHASES = 8;

   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{CMD_TICK, 3'd0, 1'b1, IDLE_RSP},
      '{CMD_REQUEST, 3'd0, 1'b1, IDLE_RSP},
      '{CMD_REQUEST, 3'd7, 1'b1, IDLE_RSP},
      '{CMD_REQUEST, 3'd6, 1'b1, IDLE_RSP},
      '{CMD_REQUEST, 3'd1, 1'b1, result_type'{3'd1, 8'd5, 3'd0, 5'b00001, 1'b1}},
      '{CMD_REQUEST, 3'd5, 1'b1, result_type'{3'd5, 8'd5, 3'd0, 5'b10001, 1'b1}},
      '{CMD_REQUEST, 3'd3, 1'b1, result_type'{3'd5, 8'd5, 3'd0, 5'b10101, 1'b0}},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd5, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd7, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd2, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd4, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd4, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd1, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd2, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd7, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_TICK, 3'd0, 1'b0, IDLE_RSP},
      '{CMD_REQUEST, 3'd1, 1'b0, IDLE_RSP}
   };

   localparam int PHASE_ITEMS [NUM_PHASES] = '{250, 200, 150, 250, 250, 250, 250, 250};
   localparam int PHASE_TICK_PCT [NUM_PHASES] = '{55, 55, 85, 60, 60, 60, 65, 60};
   localparam int PHASE_SERVICE [NUM_PHASES] = '{1, 0, 255, 2, 3, 0, 8, 4};

   logic clock;
   logic reset;

   npic_req_chan req_chan ();
   npic_rsp_chan rsp_chan ();
   npic_csr_chan csr_chan ();

   nested_priority_interrupt_controller dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan),
      .csr_if(csr_chan)
   );

   // controller model state
   ticks_type svc_ticks;
   mask_type pend_bits;
   ticks_type ticks_saved [1:LEVELS];
   level_type cur_lvl;

   result_type due_results [$];
   int mismatches;
   int responses_seen;
   bit send_idle;
   bit rx_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic level_type top_pending();
      for (int i = LEVELS; i >= 1; i--) begin
         if (pend_bits[i-1]) begin
            return level_type'(i);
         end
      end
      return '0;
   endfunction

   function automatic logic start_top();
      level_type lv;
      lv = top_pending();
      cur_lvl = lv;
      if (lv == 0) begin
         return 1'b0;
      end
      if (ticks_saved[lv] == 0) begin
         ticks_saved[lv] = (svc_ticks == 0) ? ticks_type'(1) : svc_ticks;
      end
      return 1'b1;
   endfunction

   function automatic result_type service_step(input logic cmd, input level_type lvl);
      result_type r;
      level_type done_lvl;
      logic sw;
      done_lvl = '0;
      sw = 1'b0;
      if (cmd == CMD_REQUEST) begin
         if (lvl >= 1 && lvl <= LEVELS) begin
            pend_bits[lvl-1] = 1'b1;
            if (lvl > cur_lvl) begin
               sw = start_top();
            end
         end
      end else if (cur_lvl != 0) begin
         if (ticks_saved[cur_lvl] != 0) begin
            ticks_saved[cur_lvl] = ticks_saved[cur_lvl] - 1'b1;
         end
         if (ticks_saved[cur_lvl] == 0) begin
            pend_bits[cur_lvl-1] = 1'b0;
            done_lvl = cur_lvl;
            sw = start_top();
         end
      end
      r.active_level = cur_lvl;
      r.remaining = (cur_lvl != 0) ? ticks_saved[cur_lvl] : '0;
      r.finished_level = done_lvl;
      r.pending_mask = pend_bits;
      r.switched = sw;
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   task automatic report_fault(input string msg);
      if (mismatches < 40) begin
         $display("%0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic check_response();
      result_type got;
      result_type want;
      got.active_level = rsp_chan.active_level;
      got.remaining = rsp_chan.remaining;
      got.finished_level = rsp_chan.finished_level;
      got.pending_mask = rsp_chan.pending_mask;
      got.switched = rsp_chan.switched;
      responses_seen++;
      if (due_results.size() == 0) begin
         report_fault($sformatf("response %0d with no request outstanding", responses_seen));
      end else begin
         want = due_results.pop_front();
         if (got.active_level !== want.active_level)
            report_fault($sformatf("response %0d active_level %0d, want %0d",
                                   responses_seen, got.active_level, want.active_level));
         if (got.remaining !== want.remaining)
            report_fault($sformatf("response %0d remaining %0d, want %0d",
                                   responses_seen, got.remaining, want.remaining));
         if (got.finished_level !== want.finished_level)
            report_fault($sformatf("response %0d finished_level %0d, want %0d",
                                   responses_seen, got.finished_level, want.finished_level));
         if (got.pending_mask !== want.pending_mask)
            report_fault($sformatf("response %0d pending_mask %b, want %b",
                                   responses_seen, got.pending_mask, want.pending_mask));
         if (got.switched !== want.switched)
            report_fault($sformatf("response %0d switched %b, want %b",
                                   responses_seen, got.switched, want.switched));
      end
   endtask

   task automatic offer(input logic cmd, input level_type lvl, input logic fixed_want,
                        input result_type want, input bit more);
      result_type pred;
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.level <= lvl;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred = service_step(cmd, lvl);
      due_results.push_back(fixed_want ? want : pred);
      gap = send_idle ? idle_gap() : 0;
      if (gap > 0 || !more) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_service(input ticks_type v);
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      svc_ticks = v;
      csr_chan.valid <= 1'b0;
   endtask

   // response side: random stalls plus one long hold-off to fill the output buffer
   initial begin
      int stall_left;
      int hold_left;
      bit held_once;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            check_response();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!held_once && responses_seen >= 600) begin
            held_once = 1'b1;
            hold_left = 90;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_idle && $urandom_range(0, 99) < 25) begin
            stall_left = idle_gap();
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      ticks_type v;
      logic cmd;
      level_type lvl;
      int r;
      mismatches = 0;
      responses_seen = 0;
      svc_ticks = SERVICE_RESET;
      pend_bits = '0;
      for (int i = 1; i <= LEVELS; i++) ticks_saved[i] = '0;
      cur_lvl = '0;
      send_idle = 1'b1;
      rx_idle = 1'b1;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.command <= CMD_REQUEST;
      req_chan.level <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         offer(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].lvl, DIRECTED_ROWS[i].fixed_want,
               DIRECTED_ROWS[i].want, i < NUM_ROWS - 1);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         v = (p == 5) ? ticks_type'($urandom_range(2, 12)) : ticks_type'(PHASE_SERVICE[p]);
         write_service(v);
         send_idle = (p % 3) != 2;
         rx_idle = (p % 4) != 1;
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            cmd = ($urandom_range(0, 99) < PHASE_TICK_PCT[p]) ? CMD_TICK : CMD_REQUEST;
            if ($urandom_range(0, 99) < 8) begin
               r = $urandom_range(0, 2);
               lvl = (r == 0) ? level_type'(0) : level_type'(5 + r);
            end else begin
               lvl = level_type'($urandom_range(1, LEVELS));
            end
            offer(cmd, lvl, 1'b0, IDLE_RSP, n < PHASE_ITEMS[p] - 1);
         end
      end

      while (due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("nested_priority_interrupt_controller_tb OK");
      end else begin
         $display("nested_priority_interrupt_controller_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("nested_priority_interrupt_controller_tb NOT OK");
      $finish;
   end

endmodule
